[hw/rtl/uqve_pkg.sv]
// ----------------------------------------------------------------------------
// uqve_pkg
// Shared types, codes and helpers for the URL query value extractor.
// ----------------------------------------------------------------------------
package uqve_pkg;

    localparam int KEY_MAX_BYTES = 8;
    localparam int KEY_W         = 64;
    localparam int KLEN_W        = 4;
    localparam int CFG_INDEX_W   = 1;
    localparam int RUN_MAX       = 3;
    localparam int RUN_CNT_W     = 2;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_BYTES  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE     = 2'd0,
        KIND_FOUND    = 2'd1,
        KIND_NOTFOUND = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       is_last;
    } query_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value_byte;
        logic       last_of_run;
    } result_item_t;

    typedef struct packed {
        logic [RUN_CNT_W-1:0]              count;
        result_item_t [RUN_MAX-1:0]        items;
    } result_run_t;

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    function automatic result_item_t make_item(input kind_t k, input logic [7:0] b);
        result_item_t r;
        r.kind        = k;
        r.value_byte  = b;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

[hw/rtl/url_query_value_extract.sv]
// ----------------------------------------------------------------------------
// url_query_value_extract
// Extracts and percent-decodes the value of one key from a URL query string.
// ----------------------------------------------------------------------------
// Usage:
//   query channel: one character per transaction, is_last on the final one.
//   result channel: decoded value bytes, then a found marker, or a single
//   not-found marker; last_of_run closes the results of one character.
//   cfg channel: index 0 writes the key characters, index 1 the key length;
//   writes are taken every cycle and apply to the characters that follow.
// Results: the parser is combinational; a character's results are written to the result queue when it is accepted.
// Throughput: one character per cycle while the eight-entry result queue
//   keeps room for a run of three; the result side drains one per cycle,
//   so characters that yield several results set the sustained rate.
// Reset: parse state returns to expecting '?', key registers clear and the
//   result queue empties.
// Stall: when the receiver holds off, results collect in the queue and
//   query_ready drops once fewer than three entries remain free.
// ----------------------------------------------------------------------------
module url_query_value_extract (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               query_valid,
    output logic                               query_ready,
    input  uqve_pkg::query_item_t              query,
    output logic                               result_valid,
    input  logic                               result_ready,
    output uqve_pkg::result_item_t             result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [uqve_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [uqve_pkg::KEY_W-1:0]         cfg_data
);
    import uqve_pkg::*;

    logic [KEY_W-1:0]  key_bytes_reg;
    logic [KLEN_W-1:0] key_length_reg;
    logic              advance;
    logic              room;
    result_run_t       run;

    assign cfg_ready   = 1'b1;
    assign query_ready = room;
    assign advance     = query_valid && query_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg  <= '0;
            key_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_KEY_BYTES:  key_bytes_reg  <= cfg_data;
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KLEN_W-1:0];
                default:        key_bytes_reg  <= key_bytes_reg;
            endcase
        end
    end

    uqve_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (query),
        .key_bytes  (key_bytes_reg),
        .key_length (key_length_reg),
        .run        (run)
    );

    uqve_result_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (advance),
        .run   (run),
        .room  (room),
        .valid (result_valid),
        .ready (result_ready),
        .head  (result)
    );

endmodule

[hw/rtl/uqve_parser.sv]
// ----------------------------------------------------------------------------
// uqve_parser
// Per-byte parse state and the run of up to three results for each byte.
// ----------------------------------------------------------------------------
module uqve_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  uqve_pkg::query_item_t         item,
    input  logic [uqve_pkg::KEY_W-1:0]    key_bytes,
    input  logic [uqve_pkg::KLEN_W-1:0]   key_length,
    output uqve_pkg::result_run_t         run
);
    import uqve_pkg::*;

    typedef enum logic [2:0] {
        MODE_START,
        MODE_NAME,
        MODE_SKIP,
        MODE_VALUE,
        MODE_ESC1,
        MODE_ESC2,
        MODE_DONE
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [3:0]  count_reg, count_next;
    logic        equal_reg, equal_next;
    logic [7:0]  held_reg, held_next;

    logic [KEY_MAX_BYTES-1:0][7:0] key_arr;
    logic [KLEN_W-1:0]             klen;
    logic [7:0]                    b;
    logic                          last;
    logic [RUN_CNT_W-1:0]          n;
    result_item_t [RUN_MAX-1:0]    ent;

    assign key_arr = key_bytes;
    assign b       = item.query_byte;
    assign last    = item.is_last;
    assign klen    = (key_length > KLEN_W'(KEY_MAX_BYTES)) ? KLEN_W'(KEY_MAX_BYTES)
                                                           : key_length;

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        equal_next = equal_reg;
        held_next  = held_reg;
        n          = '0;
        ent        = '0;
        unique case (mode_reg)
            MODE_START:
            begin
                if (b != CH_QMARK || last)
                begin
                    ent[n] = make_item(KIND_NOTFOUND, 8'd0);
                    n = n + 1'b1;
                    mode_next = MODE_DONE;
                end
                else
                begin
                    mode_next  = MODE_NAME;
                    count_next = '0;
                    equal_next = 1'b1;
                end
            end
            MODE_NAME:
            begin
                if (b == CH_EQ)
                begin
                    if (equal_reg && count_reg == klen)
                    begin
                        mode_next = MODE_VALUE;
                        if (last)
                        begin
                            ent[n] = make_item(KIND_FOUND, 8'd0);
                            n = n + 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next = MODE_SKIP;
                        if (last)
                        begin
                            ent[n] = make_item(KIND_NOTFOUND, 8'd0);
                            n = n + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (count_reg >= klen)
                        equal_next = 1'b0;
                    else if (key_arr[count_reg[2:0]] != b)
                        equal_next = 1'b0;
                    if (count_reg != 4'hF)
                        count_next = count_reg + 4'd1;
                    if (last)
                    begin
                        ent[n] = make_item(KIND_NOTFOUND, 8'd0);
                        n = n + 1'b1;
                    end
                end
            end
            MODE_SKIP:
            begin
                if (b == CH_AMP)
                begin
                    mode_next  = MODE_NAME;
                    count_next = '0;
                    equal_next = 1'b1;
                end
                if (last)
                begin
                    ent[n] = make_item(KIND_NOTFOUND, 8'd0);
                    n = n + 1'b1;
                end
            end
            MODE_VALUE:
            begin
                if (b == CH_PCT && !last)
                    mode_next = MODE_ESC1;
                else
                begin
                    if (b == CH_AMP)
                    begin
                        ent[n] = make_item(KIND_FOUND, 8'd0);
                        mode_next = MODE_DONE;
                    end
                    else if (b == CH_PLUS)
                        ent[n] = make_item(KIND_BYTE, CH_SPACE);
                    else
                        ent[n] = make_item(KIND_BYTE, b);
                    n = n + 1'b1;
                    if (last && b != CH_AMP)
                    begin
                        ent[n] = make_item(KIND_FOUND, 8'd0);
                        n = n + 1'b1;
                    end
                end
            end
            MODE_ESC1:
            begin
                if (last)
                begin
                    ent[n] = make_item(KIND_BYTE, CH_PCT);
                    n = n + 1'b1;
                    mode_next = MODE_VALUE;
                    if (b == CH_AMP)
                    begin
                        ent[n] = make_item(KIND_FOUND, 8'd0);
                        mode_next = MODE_DONE;
                    end
                    else if (b == CH_PLUS)
                        ent[n] = make_item(KIND_BYTE, CH_SPACE);
                    else
                        ent[n] = make_item(KIND_BYTE, b);
                    n = n + 1'b1;
                    if (b != CH_AMP)
                    begin
                        ent[n] = make_item(KIND_FOUND, 8'd0);
                        n = n + 1'b1;
                    end
                end
                else
                begin
                    held_next = b;
                    mode_next = MODE_ESC2;
                end
            end
            MODE_ESC2:
            begin
                ent[n] = make_item(KIND_BYTE, {hex_val(held_reg), hex_val(b)});
                n = n + 1'b1;
                held_next = '0;
                mode_next = MODE_VALUE;
                if (last)
                begin
                    ent[n] = make_item(KIND_FOUND, 8'd0);
                    n = n + 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_DONE;
            end
        endcase
        if (n != '0)
            ent[n - 1'b1].last_of_run = 1'b1;
        if (last)
        begin
            mode_next  = MODE_START;
            count_next = '0;
            equal_next = 1'b1;
            held_next  = '0;
        end
        run.count = n;
        run.items = ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_START;
            count_reg <= '0;
            equal_reg <= 1'b1;
            held_reg  <= '0;
        end
        else if (advance)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            equal_reg <= equal_next;
            held_reg  <= held_next;
        end
    end

endmodule

[hw/rtl/uqve_result_queue.sv]
// ----------------------------------------------------------------------------
// uqve_result_queue
// Result queue: takes a run of up to three items per cycle while it has room, drains one.
// ----------------------------------------------------------------------------
module uqve_result_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  uqve_pkg::result_run_t    run,
    output logic                     room,
    output logic                     valid,
    input  logic                     ready,
    output uqve_pkg::result_item_t   head
);
    import uqve_pkg::*;

    localparam int DEPTH   = 8;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    result_item_t         mem [DEPTH];
    logic [PTR_W-1:0]     wptr_reg, wptr_next;
    logic [PTR_W-1:0]     rptr_reg, rptr_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [RUN_CNT_W-1:0] n_push;
    logic                 pop;

    assign n_push = push ? run.count : '0;
    assign pop    = valid && ready;
    assign valid  = count_reg != '0;
    assign room   = count_reg <= COUNT_W'(DEPTH - RUN_MAX);
    assign head   = mem[rptr_reg];

    assign wptr_next  = wptr_reg + PTR_W'(n_push);
    assign rptr_next  = rptr_reg + PTR_W'(pop);
    assign count_next = count_reg + COUNT_W'(n_push) - COUNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RUN_MAX; i++)
        begin
            if (RUN_CNT_W'(i) < n_push)
                mem[wptr_reg + PTR_W'(i)] <= run.items[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/uqve_checker.sv]
// ----------------------------------------------------------------------------
// uqve_checker
// Port-level checks for url_query_value_extract, bound to the top level.
// ----------------------------------------------------------------------------
module uqve_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     query_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input uqve_pkg::result_item_t   result
);
    import uqve_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.kind == KIND_BYTE || result.kind == KIND_FOUND
                          || result.kind == KIND_NOTFOUND))
        else $error("illegal result kind");

    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind != KIND_BYTE
            |-> result.last_of_run && result.value_byte == 8'd0)
        else $error("marker not closing its run");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !query_ready |-> result_valid)
        else $error("query held off with empty result queue");

endmodule

bind url_query_value_extract uqve_checker u_uqve_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_ready  (query_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for url_query_value_extract.
// A short table of query strings covers the edge cases first. Random strings
// then follow under several key settings, first with random stalls on both
// channels, then without. Most table rows state their result; an in-bench
// decoder model predicts the rest; all are compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;

    import uqve_pkg::*;

    typedef enum logic [2:0] {
        P_START,
        P_NAME,
        P_SKIP,
        P_VALUE,
        P_ESC1,
        P_ESC2,
        P_DONE
    } parse_state_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic       has_result;
        kind_t      kind;
        logic [7:0] vbyte;
    } stim_row_t;

    localparam int NUM_ROWS    = 25;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_CHARS = 73;

    localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{8'hFF,    1'b1, 1'b1, 1'b1, KIND_NOTFOUND, 8'h00},
        '{CH_QMARK, 1'b1, 1'b1, 1'b1, KIND_NOTFOUND, 8'h00},
        '{CH_QMARK, 1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"a",      1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"b",      1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_EQ,    1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_PLUS,  1'b0, 1'b1, 1'b1, KIND_BYTE,     CH_SPACE},
        '{CH_PCT,   1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"F",      1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"f",      1'b0, 1'b1, 1'b1, KIND_BYTE,     8'hFF},
        '{CH_PCT,   1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_AMP,   1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"z",      1'b0, 1'b1, 1'b1, KIND_BYTE,     8'h00},
        '{8'h00,    1'b0, 1'b1, 1'b1, KIND_BYTE,     8'h00},
        '{CH_PCT,   1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_AMP,   1'b1, 1'b0, 1'b0, KIND_BYTE,     8'h00},
        '{CH_QMARK, 1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"x",      1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_EQ,    1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_AMP,   1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"a",      1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"b",      1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{CH_EQ,    1'b1, 1'b1, 1'b1, KIND_FOUND,    8'h00},
        '{CH_QMARK, 1'b0, 1'b1, 1'b0, KIND_BYTE,     8'h00},
        '{"a",      1'b1, 1'b1, 1'b1, KIND_NOTFOUND, 8'h00}
    };

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   query_valid = 1'b0;
    logic                   query_ready;
    query_item_t            query = '0;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    result_item_t           result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]       cfg_data = '0;

    int send_idle_pct = 29;
    int recv_idle_pct = 70;
    int error_count = 0;

    logic [KEY_W-1:0]  key_reg = '0;
    logic [KLEN_W-1:0] key_len_reg = '0;
    parse_state_t      parse_state = P_START;
    logic [3:0]        name_len = '0;
    logic              name_match = 1'b1;
    logic [7:0]        esc_hi = '0;

    result_item_t step_results[$];
    result_item_t pending_results[$];
    query_item_t  char_backlog[$];

    url_query_value_extract DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_ready  (query_ready),
        .query        (query),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= "0" && c <= "9")
            v = c[3:0];
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            v = 4'(c[2:0] + 4'd9);
        return v;
    endfunction

    function automatic void add_result(input kind_t k, input logic [7:0] b);
        result_item_t r;
        r.kind        = k;
        r.value_byte  = b;
        r.last_of_run = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void value_char(input logic [7:0] b);
        if (b == CH_AMP)
        begin
            parse_state = P_DONE;
            add_result(KIND_FOUND, 8'h00);
        end
        else if (b == CH_PLUS)
            add_result(KIND_BYTE, CH_SPACE);
        else
            add_result(KIND_BYTE, b);
    endfunction

    function automatic void restart_name();
        name_len   = 4'd0;
        name_match = 1'b1;
    endfunction

    function automatic void extract_step(input query_item_t q);
        logic [7:0]        b;
        logic              fin;
        logic [KLEN_W-1:0] klen;
        b    = q.query_byte;
        fin  = q.is_last;
        klen = (key_len_reg > KEY_MAX_BYTES) ? KLEN_W'(KEY_MAX_BYTES) : key_len_reg;
        step_results.delete();
        case (parse_state)
            P_START:
                if (b != CH_QMARK || fin)
                begin
                    add_result(KIND_NOTFOUND, 8'h00);
                    parse_state = P_DONE;
                end
                else
                begin
                    parse_state = P_NAME;
                    restart_name();
                end
            P_NAME:
                if (b == CH_EQ)
                begin
                    if (name_match && name_len == klen)
                    begin
                        parse_state = P_VALUE;
                        if (fin)
                            add_result(KIND_FOUND, 8'h00);
                    end
                    else
                    begin
                        parse_state = P_SKIP;
                        if (fin)
                            add_result(KIND_NOTFOUND, 8'h00);
                    end
                end
                else
                begin
                    if (name_len >= klen)
                        name_match = 1'b0;
                    else if (key_reg[name_len[2:0]*8 +: 8] != b)
                        name_match = 1'b0;
                    if (name_len != 4'd15)
                        name_len = name_len + 4'd1;
                    if (fin)
                        add_result(KIND_NOTFOUND, 8'h00);
                end
            P_SKIP:
            begin
                if (b == CH_AMP)
                begin
                    parse_state = P_NAME;
                    restart_name();
                end
                if (fin)
                    add_result(KIND_NOTFOUND, 8'h00);
            end
            P_VALUE:
                if (b == CH_PCT && !fin)
                    parse_state = P_ESC1;
                else
                begin
                    value_char(b);
                    if (fin && parse_state != P_DONE)
                        add_result(KIND_FOUND, 8'h00);
                end
            P_ESC1:
                if (fin)
                begin
                    add_result(KIND_BYTE, CH_PCT);
                    parse_state = P_VALUE;
                    value_char(b);
                    if (parse_state != P_DONE)
                        add_result(KIND_FOUND, 8'h00);
                end
                else
                begin
                    esc_hi      = b;
                    parse_state = P_ESC2;
                end
            P_ESC2:
            begin
                add_result(KIND_BYTE, {hex_nibble(esc_hi), hex_nibble(b)});
                esc_hi      = 8'h00;
                parse_state = P_VALUE;
                if (fin)
                    add_result(KIND_FOUND, 8'h00);
            end
            default:
                parse_state = P_DONE;
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size()-1].last_of_run = 1'b1;
        if (fin)
        begin
            parse_state = P_START;
            esc_hi      = 8'h00;
            restart_name();
        end
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(8'h7A, 8'h61));
    endfunction

    function automatic logic [7:0] random_hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        if ($urandom_range(9) == 0)
            return 8'($urandom_range(255));
        return digits[$urandom_range(21)];
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < KEY_MAX_BYTES; i++)
            k[i*8 +: 8] = random_letter();
        return k;
    endfunction

    function automatic void build_query_string();
        logic [7:0]  s[$];
        query_item_t q;
        int          kl;
        int          segs;
        int          pick;
        int          n;
        int          base;
        int          idx;
        kl = (key_len_reg > KEY_MAX_BYTES) ? KEY_MAX_BYTES : int'(key_len_reg);
        if ($urandom_range(9) == 0)
            s.push_back(8'($urandom_range(255)));
        else
            s.push_back(CH_QMARK);
        segs = $urandom_range(3, 1);
        for (int i = 0; i < segs; i++)
        begin
            if (i > 0)
                s.push_back(CH_AMP);
            base = s.size();
            pick = $urandom_range(9);
            if (pick < 7)
            begin
                for (int j = 0; j < kl; j++)
                    s.push_back(key_reg[j*8 +: 8]);
                if (pick >= 5)
                begin
                    if (kl > 0 && $urandom_range(1) == 0)
                    begin
                        idx    = base + $urandom_range(kl - 1);
                        s[idx] = s[idx] ^ 8'h20;
                    end
                    else
                        s.push_back(random_letter());
                end
            end
            else
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(17, 9) : $urandom_range(4);
                for (int j = 0; j < n; j++)
                    s.push_back(random_letter());
            end
            if ($urandom_range(9) != 0)
                s.push_back(CH_EQ);
            n = $urandom_range(6);
            for (int j = 0; j < n; j++)
            begin
                pick = $urandom_range(19);
                if (pick < 4)
                begin
                    s.push_back(CH_PCT);
                    s.push_back(random_hex_char());
                    s.push_back(random_hex_char());
                end
                else if (pick < 6)
                    s.push_back(CH_PLUS);
                else if (pick < 8)
                    s.push_back(8'($urandom_range(255)));
                else
                    s.push_back(random_hex_char());
            end
        end
        if ($urandom_range(7) == 0)
        begin
            n = $urandom_range(s.size(), 1);
            while (s.size() > n)
                void'(s.pop_back());
        end
        for (int j = 0; j < s.size(); j++)
        begin
            q.query_byte = s[j];
            q.is_last    = (j == s.size() - 1);
            char_backlog.push_back(q);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, wanted);
        error_count++;
    endtask

    task automatic push_query(input query_item_t q, input logic typed,
                              input logic has_result, input result_item_t typed_result);
        if ($urandom_range(99) < send_idle_pct)
        begin
            query_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        query_valid <= 1'b1;
        query       <= q;
        @(posedge clk);
        while (!query_ready)
            @(posedge clk);
        extract_step(q);
        if (!typed)
        begin
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        end
        else if (has_result)
            pending_results.push_back(typed_result);
    endtask

    task automatic program_key(input logic [KEY_W-1:0] kb, input logic [KLEN_W-1:0] kl);
        cfg_valid <= 1'b1;
        cfg_index <= REG_KEY_BYTES;
        cfg_data  <= kb;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_reg = kb;
        cfg_index <= REG_KEY_LENGTH;
        cfg_data  <= KEY_W'(kl);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_len_reg = kl;
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        query_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : check_results
        result_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none pending", int'(result), 0);
            else
            begin
                want = pending_results.pop_front();
                if (result.kind != want.kind)
                    report_mismatch("kind", result.kind, want.kind);
                if (result.value_byte != want.value_byte)
                    report_mismatch("value_byte", result.value_byte, want.value_byte);
                if (result.last_of_run != want.last_of_run)
                    report_mismatch("last_of_run", result.last_of_run, want.last_of_run);
            end
        end
    end

    initial
    begin
        stim_row_t    row;
        query_item_t  q;
        result_item_t r;
        int           sent;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        program_key(64'h6261, 4'd2);
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row           = DIRECTED_ROWS[i];
            q.query_byte  = row.ch;
            q.is_last     = row.fin;
            r.kind        = row.kind;
            r.value_byte  = row.vbyte;
            r.last_of_run = 1'b1;
            push_query(q, row.typed, row.has_result, r);
        end

        r = '0;
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            send_idle_pct = (ph < 2) ? 29 : (ph < 4) ? 70 : 0;
            recv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 29 : 0;
            case (ph)
                0:       program_key(random_key(), 4'd3);
                1:       program_key('1, 4'd8);
                2:       program_key('0, 4'd0);
                3:       program_key({$urandom, $urandom}, 4'd15);
                4:       program_key(random_key(), 4'd5);
                default: program_key(random_key(), 4'd1);
            endcase
            sent = 0;
            while (sent < PHASE_CHARS)
            begin
                if (char_backlog.size() == 0)
                    build_query_string();
                sent++;
                push_query(char_backlog.pop_front(), 1'b0, 1'b0, r);
            end
        end
        while (char_backlog.size() != 0)
            push_query(char_backlog.pop_front(), 1'b0, 1'b0, r);

        settle();
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
hw/rtl/uqve_pkg.sv
hw/rtl/uqve_parser.sv
hw/rtl/uqve_result_queue.sv
hw/rtl/url_query_value_extract.sv
hw/rtl/uqve_checker.sv
tb/tb.sv
